// ===== hw/rtl/pgat_pkg.sv =====
// Shared types, constants, microcode ROM and saturation helpers for the
// presence-gated alpha-beta-gamma tracker. No dependencies.
`timescale 1ns / 1ps

package pgat_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int EST_W      = 32;   // estimate width
    localparam int RES_W      = 34;   // residual width
    localparam int ACC_W      = 48;   // accumulator width
    localparam int MA_W       = 33;   // multiplier operand A (gains and step terms, zero-extended)
    localparam int MB_W       = 34;   // multiplier operand B (estimates, residual)
    localparam int PROD_W     = MA_W + MB_W;
    localparam int POS_W      = 24;
    localparam int PRIOR_W    = 24;
    localparam int CNT_W      = 8;
    localparam int THR_W      = 10;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] ALPHA_RST = 16'd32768;
    localparam logic [15:0] BETA_RST  = 16'd1536;
    localparam logic [15:0] GAMMA_RST = 16'd51200;
    localparam logic [23:0] STEP_RST  = 24'd83886;
    localparam logic [31:0] HSS_RST   = 32'd53687;
    localparam logic [THR_W-1:0] THR_RST   = 10'd80;
    localparam logic [THR_W-1:0] GLITCH_RST = 10'd170;
    localparam logic [CNT_W-1:0] LIMIT_RST = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA  = 4'd0,
        REG_BETA   = 4'd1,
        REG_GAMMA  = 4'd2,
        REG_STEP   = 4'd3,
        REG_HSS    = 4'd4,
        REG_THRESH = 4'd5,
        REG_GLITCH = 4'd6,
        REG_LIMIT  = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0]      alpha_gain;
        logic [15:0]      beta_over_step;
        logic [15:0]      gamma_over_step;
        logic [23:0]      step_time;
        logic [31:0]      half_step_squared;
        logic [THR_W-1:0] presence_threshold;
        logic [THR_W-1:0] glitch_bound;
        logic [CNT_W-1:0] count_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        MA_STEP  = 3'd0,
        MA_HSS   = 3'd1,
        MA_ALPHA = 3'd2,
        MA_BETA  = 3'd3,
        MA_GAMMA = 3'd4
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_VEL = 2'd0,
        MB_ACC = 2'd1,
        MB_RES = 2'd2
    } mul_b_t;

    typedef enum logic [2:0] {
        BS_POS   = 3'd0,
        BS_VEL   = 3'd1,
        BS_ACC   = 3'd2,
        BS_PPRED = 3'd3,
        BS_VPRED = 3'd4
    } base_t;

    typedef enum logic [1:0] {
        SH_8  = 2'd0,
        SH_16 = 2'd1,
        SH_24 = 2'd2,
        SH_32 = 2'd3
    } shift_t;

    typedef enum logic [1:0] {
        CM_NONE = 2'd0,
        CM_CORR = 2'd1,
        CM_HOLD = 2'd2,
        CM_PASS = 2'd3
    } commit_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

    typedef struct packed {
        mul_a_t              mul_a;
        mul_b_t              mul_b;
        logic                acc_load;
        base_t               acc_base;
        logic                acc_add;
        shift_t              shift;
        logic                wr_ppred;
        logic                wr_vpred;
        logic                wr_res;
        logic                jump_glitch;
        logic [STEP_W-1:0]   jump_to;
        commit_t             commit;
    } ctrl_t;

    typedef struct packed {
        logic glitch;
        logic out_free;
    } seq_stat_t;

    localparam logic [STEP_W-1:0] ADDR_TRACK = 4'd0;
    localparam logic [STEP_W-1:0] ADDR_HOLD  = 4'd10;
    localparam logic [STEP_W-1:0] ADDR_PASS  = 4'd11;

    localparam ctrl_t CTRL_NOP = '{
        mul_a: MA_STEP, mul_b: MB_VEL, acc_load: 1'b0, acc_base: BS_POS,
        acc_add: 1'b0, shift: SH_8, wr_ppred: 1'b0, wr_vpred: 1'b0,
        wr_res: 1'b0, jump_glitch: 1'b0, jump_to: '0, commit: CM_NONE
    };

    // Tracker microprogram. Products are registered and are added in the step after their issue.
    function automatic ctrl_t rom_word(input logic [STEP_W-1:0] addr);
        ctrl_t c;
        c = CTRL_NOP;
        case (addr)
            4'd0: begin        // issue step*vel, acc = pos
                c.mul_a = MA_STEP;  c.mul_b = MB_VEL;
                c.acc_load = 1'b1;  c.acc_base = BS_POS;
            end
            4'd1: begin        // issue hss*acc, add step*vel term
                c.mul_a = MA_HSS;   c.mul_b = MB_ACC;
                c.acc_add = 1'b1;   c.shift = SH_24;
            end
            4'd2: begin        // issue step*acc, add hss*acc term
                c.mul_a = MA_STEP;  c.mul_b = MB_ACC;
                c.acc_add = 1'b1;   c.shift = SH_32;
            end
            4'd3: begin        // predicted position, acc = vel + step*acc term
                c.wr_ppred = 1'b1;
                c.acc_load = 1'b1;  c.acc_base = BS_VEL;
                c.acc_add = 1'b1;   c.shift = SH_24;
            end
            4'd4: begin        // predicted velocity, residual
                c.wr_vpred = 1'b1;
                c.wr_res = 1'b1;
            end
            4'd5: begin        // issue alpha*r, skip correction on a glitch
                c.mul_a = MA_ALPHA; c.mul_b = MB_RES;
                c.jump_glitch = 1'b1; c.jump_to = ADDR_HOLD;
            end
            4'd6: begin
                c.mul_a = MA_BETA;  c.mul_b = MB_RES;
                c.acc_load = 1'b1;  c.acc_base = BS_PPRED;
                c.acc_add = 1'b1;   c.shift = SH_16;
            end
            4'd7: begin
                c.mul_a = MA_GAMMA; c.mul_b = MB_RES;
                c.wr_ppred = 1'b1;
                c.acc_load = 1'b1;  c.acc_base = BS_VPRED;
                c.acc_add = 1'b1;   c.shift = SH_8;
            end
            4'd8: begin
                c.wr_vpred = 1'b1;
                c.acc_load = 1'b1;  c.acc_base = BS_ACC;
                c.acc_add = 1'b1;   c.shift = SH_8;
            end
            4'd9:  c.commit = CM_CORR;
            4'd10: c.commit = CM_HOLD;
            4'd11: c.commit = CM_PASS;
            default: c = CTRL_NOP;
        endcase
        return c;
    endfunction

    function automatic logic signed [EST_W-1:0] sat_est(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed({{(ACC_W-EST_W+1){1'b0}}, {(EST_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return $signed({1'b0, {(EST_W-1){1'b1}}});
        end else if (v < lo) begin
            return $signed({1'b1, {(EST_W-1){1'b0}}});
        end
        return v[EST_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [RES_W-1:0] v);
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        hi = $signed({{(RES_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return $signed({1'b0, {(POS_W-1){1'b1}}});
        end else if (v < lo) begin
            return $signed({1'b1, {(POS_W-1){1'b0}}});
        end
        return v[POS_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pgat_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and glitch jump.
// Depends on pgat_pkg.
`timescale 1ns / 1ps

module pgat_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pgat_pkg::STEP_W-1:0]  start_addr,
    input  pgat_pkg::seq_stat_t          stat,
    output pgat_pkg::ctrl_t              ctrl,
    output logic                         busy,
    output logic                         fire
);

    pgat_pkg::seq_state_t        state_reg, state_next;
    logic [pgat_pkg::STEP_W-1:0] pc_reg, pc_next;
    pgat_pkg::ctrl_t             word;
    logic                        commit_step;

    assign word        = pgat_pkg::rom_word(pc_reg);
    assign commit_step = (word.commit != pgat_pkg::CM_NONE);

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            pgat_pkg::SEQ_IDLE: begin
                if (start) begin
                    state_next = pgat_pkg::SEQ_RUN;
                    pc_next    = start_addr;
                end
            end
            pgat_pkg::SEQ_RUN: begin
                if (commit_step) begin
                    // hold on the commit step until the result slot frees
                    if (stat.out_free) begin
                        state_next = pgat_pkg::SEQ_IDLE;
                    end
                end else if (word.jump_glitch && stat.glitch) begin
                    pc_next = word.jump_to;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            default: state_next = pgat_pkg::SEQ_IDLE;
        endcase
    end

    always_comb begin
        ctrl = pgat_pkg::CTRL_NOP;
        busy = 1'b0;
        fire = 1'b0;
        case (state_reg)
            pgat_pkg::SEQ_IDLE: ;
            pgat_pkg::SEQ_RUN: begin
                ctrl = word;
                busy = 1'b1;
                fire = commit_step && stat.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pgat_pkg::SEQ_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

// ===== hw/rtl/pgat_dp.sv =====
// Tracker datapath: shared multiplier, accumulator, predicted terms, residual
// and the three estimates. Driven by control words; depends on pgat_pkg.
`timescale 1ns / 1ps

module pgat_dp #(
    parameter int SAMPLE_BITS = pgat_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = pgat_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pgat_pkg::ctrl_t                       ctrl,
    input  logic                                  fire,
    input  logic                                  est_clear,
    input  pgat_pkg::cfg_t                        cfg,
    input  logic [SAMPLE_BITS-1:0]                raw,
    input  logic signed [pgat_pkg::PRIOR_W-1:0]   prior,
    output logic                                  glitch,
    output logic signed [pgat_pkg::POS_W-1:0]     pos_result
);

    localparam int EW = pgat_pkg::EST_W;
    localparam int AW = pgat_pkg::ACC_W;
    localparam int RW = pgat_pkg::RES_W;
    localparam int PW = pgat_pkg::PROD_W;

    logic signed [EW-1:0] pos_reg, vel_reg, accel_reg;
    logic signed [EW-1:0] ppred_reg, vpred_reg;
    logic signed [RW-1:0] res_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] prod_reg;

    logic signed [pgat_pkg::MA_W-1:0] mul_a;
    logic signed [pgat_pkg::MB_W-1:0] mul_b;
    logic signed [AW-1:0] base_v, term_v;
    logic signed [PW-1:0] prod_sh;
    logic signed [RW-1:0] raw_q, gb_neg, ppred_x;
    logic signed [EW-1:0] acc_sat;

    assign raw_q   = $signed(RW'(raw) << FRAC_BITS);
    assign gb_neg  = -$signed(RW'(cfg.glitch_bound) << FRAC_BITS);
    assign ppred_x = {{(RW-EW){ppred_reg[EW-1]}}, ppred_reg};
    assign glitch  = (res_reg < gb_neg);
    assign acc_sat = pgat_pkg::sat_est(acc_reg);

    always_comb begin
        case (ctrl.mul_a)
            pgat_pkg::MA_STEP:  mul_a = $signed({9'd0, cfg.step_time});
            pgat_pkg::MA_HSS:   mul_a = $signed({1'b0, cfg.half_step_squared});
            pgat_pkg::MA_ALPHA: mul_a = $signed({17'd0, cfg.alpha_gain});
            pgat_pkg::MA_BETA:  mul_a = $signed({17'd0, cfg.beta_over_step});
            pgat_pkg::MA_GAMMA: mul_a = $signed({17'd0, cfg.gamma_over_step});
            default:            mul_a = '0;
        endcase
        case (ctrl.mul_b)
            pgat_pkg::MB_VEL: mul_b = {{2{vel_reg[EW-1]}}, vel_reg};
            pgat_pkg::MB_ACC: mul_b = {{2{accel_reg[EW-1]}}, accel_reg};
            pgat_pkg::MB_RES: mul_b = res_reg;
            default:          mul_b = '0;
        endcase
    end

    always_comb begin
        case (ctrl.acc_base)
            pgat_pkg::BS_POS:   base_v = {{(AW-EW){pos_reg[EW-1]}}, pos_reg};
            pgat_pkg::BS_VEL:   base_v = {{(AW-EW){vel_reg[EW-1]}}, vel_reg};
            pgat_pkg::BS_ACC:   base_v = {{(AW-EW){accel_reg[EW-1]}}, accel_reg};
            pgat_pkg::BS_PPRED: base_v = {{(AW-EW){ppred_reg[EW-1]}}, ppred_reg};
            pgat_pkg::BS_VPRED: base_v = {{(AW-EW){vpred_reg[EW-1]}}, vpred_reg};
            default:            base_v = '0;
        endcase
        // floor scaling: arithmetic shift of the registered product
        case (ctrl.shift)
            pgat_pkg::SH_8:  prod_sh = prod_reg >>> 8;
            pgat_pkg::SH_16: prod_sh = prod_reg >>> 16;
            pgat_pkg::SH_24: prod_sh = prod_reg >>> 24;
            pgat_pkg::SH_32: prod_sh = prod_reg >>> 32;
            default:         prod_sh = '0;
        endcase
        term_v   = $signed(prod_sh[AW-1:0]);
        acc_next = (ctrl.acc_load ? base_v : acc_reg) + (ctrl.acc_add ? term_v : '0);
    end

    always_comb begin
        if (ctrl.commit == pgat_pkg::CM_PASS) begin
            pos_result = pgat_pkg::sat_pos(raw_q);
        end else begin
            pos_result = pgat_pkg::sat_pos(ppred_x);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        if (ctrl.wr_ppred) begin
            ppred_reg <= acc_sat;
        end
        if (ctrl.wr_vpred) begin
            vpred_reg <= acc_sat;
        end
        if (ctrl.wr_res) begin
            res_reg <= raw_q - ppred_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            vel_reg   <= '0;
            accel_reg <= '0;
        end else if (est_clear) begin
            pos_reg   <= '0;
            vel_reg   <= '0;
            accel_reg <= '0;
        end else if (fire) begin
            case (ctrl.commit)
                pgat_pkg::CM_CORR: begin
                    pos_reg   <= ppred_reg;
                    vel_reg   <= vpred_reg;
                    accel_reg <= acc_sat;
                end
                pgat_pkg::CM_HOLD: begin
                    pos_reg <= ppred_reg;
                    vel_reg <= vpred_reg;
                end
                pgat_pkg::CM_PASS: begin
                    pos_reg <= {{(EW-pgat_pkg::PRIOR_W){prior[pgat_pkg::PRIOR_W-1]}}, prior};
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/presence_gated_abg_tracker.sv =====
// Top level: configuration registers, presence tracking, item handshakes and
// result register around the microcoded tracker. Uses pgat_pkg, pgat_seq, pgat_dp.
//
//   channel   direction  handshake             payload
//   s_        in         s_valid / s_ready     s_raw_sample, s_prior_smoothed
//   m_        out        m_valid / m_ready     m_position_out, m_object_present,
//                                              m_tracking_active, m_glitch_held
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A passthrough item goes straight to the pass commit step; a tracked item runs
// the ten-step microprogram (a glitch skips the correction and jumps to the
// hold commit step), sharing one registered multiplier.
// s_ready is high whenever the sequencer is idle, including while a result waits.
// The commit step holds while the result register is full and not being taken.
// Reset is synchronous, active low; it loads register defaults and clears state.
`timescale 1ns / 1ps

module presence_gated_abg_tracker #(
    parameter int SAMPLE_BITS = pgat_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = pgat_pkg::FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [SAMPLE_BITS-1:0]                  s_raw_sample,
    input  logic signed [pgat_pkg::PRIOR_W-1:0]     s_prior_smoothed,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [pgat_pkg::POS_W-1:0]       m_position_out,
    output logic                                    m_object_present,
    output logic                                    m_tracking_active,
    output logic                                    m_glitch_held,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pgat_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pgat_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int CW    = pgat_pkg::CNT_W;
    localparam int CMP_W = (SAMPLE_BITS > pgat_pkg::THR_W) ? SAMPLE_BITS : pgat_pkg::THR_W;

    pgat_pkg::cfg_t cfg_reg;

    logic          present_reg;
    logic [CW-1:0] low_reg, prc_reg;

    logic                                raw_c_pres;
    logic [CW-1:0]                       low_c, prc_c;
    logic                                pres_c, lost_c, track_c;
    logic [CMP_W-1:0]                    raw_cmp, thr_cmp;

    logic [SAMPLE_BITS-1:0]              raw_reg;
    logic signed [pgat_pkg::PRIOR_W-1:0] prior_reg;

    logic                                m_valid_reg;
    logic signed [pgat_pkg::POS_W-1:0]   pos_out_reg;
    logic                                present_out_reg, track_out_reg, glitch_out_reg;

    logic                accept, busy, fire, out_free, glitch;
    pgat_pkg::ctrl_t     ctrl;
    pgat_pkg::seq_stat_t stat;
    logic signed [pgat_pkg::POS_W-1:0] pos_result;

    assign s_ready   = !busy;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign stat      = '{glitch: glitch, out_free: out_free};

    assign m_valid           = m_valid_reg;
    assign m_position_out    = pos_out_reg;
    assign m_object_present  = present_out_reg;
    assign m_tracking_active = track_out_reg;
    assign m_glitch_held     = glitch_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha_gain         <= pgat_pkg::ALPHA_RST;
            cfg_reg.beta_over_step     <= pgat_pkg::BETA_RST;
            cfg_reg.gamma_over_step    <= pgat_pkg::GAMMA_RST;
            cfg_reg.step_time          <= pgat_pkg::STEP_RST;
            cfg_reg.half_step_squared  <= pgat_pkg::HSS_RST;
            cfg_reg.presence_threshold <= pgat_pkg::THR_RST;
            cfg_reg.glitch_bound       <= pgat_pkg::GLITCH_RST;
            cfg_reg.count_limit        <= pgat_pkg::LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (pgat_pkg::cfg_idx_t'(cfg_index))
                pgat_pkg::REG_ALPHA:  cfg_reg.alpha_gain         <= cfg_data[15:0];
                pgat_pkg::REG_BETA:   cfg_reg.beta_over_step     <= cfg_data[15:0];
                pgat_pkg::REG_GAMMA:  cfg_reg.gamma_over_step    <= cfg_data[15:0];
                pgat_pkg::REG_STEP:   cfg_reg.step_time          <= cfg_data[23:0];
                pgat_pkg::REG_HSS:    cfg_reg.half_step_squared  <= cfg_data[31:0];
                pgat_pkg::REG_THRESH: cfg_reg.presence_threshold <= cfg_data[9:0];
                pgat_pkg::REG_GLITCH: cfg_reg.glitch_bound       <= cfg_data[9:0];
                pgat_pkg::REG_LIMIT:  cfg_reg.count_limit        <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // presence and run counters for the item on the input port
    always_comb begin
        raw_cmp    = CMP_W'(s_raw_sample);
        thr_cmp    = CMP_W'(cfg_reg.presence_threshold);
        pres_c     = present_reg;
        low_c      = low_reg;
        prc_c      = prc_reg;
        lost_c     = 1'b0;
        raw_c_pres = (raw_cmp > thr_cmp);
        if (pres_c) begin
            if (prc_c != '1) begin
                prc_c = prc_c + 1'b1;
            end
            if (raw_cmp < thr_cmp) begin
                if (low_c != '1) begin
                    low_c = low_c + 1'b1;
                end
                if (low_c > cfg_reg.count_limit) begin
                    pres_c = 1'b0;
                    lost_c = 1'b1;
                end
            end else begin
                low_c = '0;
            end
        end
        if (!pres_c) begin
            low_c = '0;
            prc_c = '0;
            if (raw_c_pres) begin
                pres_c = 1'b1;
            end
        end
        track_c = pres_c && (prc_c > cfg_reg.count_limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            low_reg     <= '0;
            prc_reg     <= '0;
        end else if (accept) begin
            present_reg <= pres_c;
            low_reg     <= low_c;
            prc_reg     <= prc_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            raw_reg   <= s_raw_sample;
            prior_reg <= s_prior_smoothed;
        end
    end

    pgat_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .start_addr (track_c ? pgat_pkg::ADDR_TRACK : pgat_pkg::ADDR_PASS),
        .stat       (stat),
        .ctrl       (ctrl),
        .busy       (busy),
        .fire       (fire)
    );

    pgat_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .fire       (fire),
        .est_clear  (accept && lost_c),
        .cfg        (cfg_reg),
        .raw        (raw_reg),
        .prior      (prior_reg),
        .glitch     (glitch),
        .pos_result (pos_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            pos_out_reg     <= pos_result;
            present_out_reg <= present_reg;
            track_out_reg   <= (ctrl.commit != pgat_pkg::CM_PASS);
            glitch_out_reg  <= (ctrl.commit == pgat_pkg::CM_HOLD);
        end
    end

    ap_glitch_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_glitch_held) |-> m_tracking_active)
        else $error("glitch hold reported on a passthrough item");

    ap_track_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tracking_active) |-> m_object_present)
        else $error("tracking reported without presence");

    ap_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer did not start on an accepted item");

    ap_absent_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        !present_reg |-> (low_reg == '0 && prc_reg == '0))
        else $error("run counters nonzero while absent");

endmodule
